FILE: sv/tpca_pkg.sv
// ----------------------------------------------------------------------------
// tpca_pkg
// Shared types and constants for the touch point calibration and averaging
// block.
// ----------------------------------------------------------------------------
package tpca_pkg;

   localparam int RAW_W     = 16;
   localparam int CAL_W     = 12;
   localparam int PT_W      = 11;
   localparam int PROD_W    = CAL_W + PT_W;
   localparam int RAW_SHIFT = 4;
   localparam int CSR_IDX_W = 3;

   localparam logic [CAL_W-1:0] CAL_LOW_RESET  = 12'd200;
   localparam logic [CAL_W-1:0] CAL_HIGH_RESET = 12'd3800;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_X_LOW_CAL  = 3'd0,
      REG_Y_LOW_CAL  = 3'd1,
      REG_X_HIGH_CAL = 3'd2,
      REG_Y_HIGH_CAL = 3'd3,
      REG_INVERT_X   = 3'd4,
      REG_INVERT_Y   = 3'd5,
      REG_SWAP_AXES  = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic             pen_line;
      logic [RAW_W-1:0] raw_x_word;
      logic [RAW_W-1:0] raw_y_word;
   } req_type;

   typedef struct packed {
      logic [PT_W-1:0] point_x;
      logic [PT_W-1:0] point_y;
      logic            pressed;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic prep;
      logic mul;
      logic scale_go;
      logic post;
      logic avg_go;
      logic hold;
      logic clear;
      logic emit;
   } ctl_cmd_type;

   typedef struct packed {
      logic pen_line;
      logic div_done;
   } ctl_status_type;

endpackage

FILE: sv/tpca_div.sv
// ----------------------------------------------------------------------------
// tpca_div
// Restoring unsigned divider, one quotient bit per cycle. Pulses done in the
// cycle in which the last bit is settled; quotient holds until the next start.
// ----------------------------------------------------------------------------
module tpca_div #(
   parameter int NUM_W = 23,
   parameter int DEN_W = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic [NUM_W-1:0] quotient,
   output logic             done
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             done_ff;
   logic [DEN_W:0]   trial;
   logic             fits;

   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else if (start) begin
         cnt_ff  <= CNT_W'(NUM_W);
         done_ff <= 1'b0;
      end else if (cnt_ff != '0) begin
         cnt_ff  <= cnt_ff - 1'b1;
         done_ff <= cnt_ff == CNT_W'(1);
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (cnt_ff != '0) begin
         quo_ff <= {quo_ff[NUM_W-2:0], fits};
         rem_ff <= fits ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

FILE: sv/tpca_ctrl.sv
// ----------------------------------------------------------------------------
// tpca_ctrl
// Sequencer for one poll: offset, multiply, scale divide, history update,
// average divide, result register hand-off; released polls skip to hand-off.
// ----------------------------------------------------------------------------
module tpca_ctrl
   import tpca_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   input  ctl_status_type status,
   output ctl_cmd_type    cmd
);

   typedef enum logic [8:0] {
      S_IDLE       = 9'b000000001,
      S_PREP       = 9'b000000010,
      S_MUL        = 9'b000000100,
      S_SCALE_GO   = 9'b000001000,
      S_SCALE_WAIT = 9'b000010000,
      S_POST       = 9'b000100000,
      S_AVG_GO     = 9'b001000000,
      S_AVG_WAIT   = 9'b010000000,
      S_EMIT       = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      emit_fire;

   assign emit_fire = (state_ff == S_EMIT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            if (status.pen_line) begin
               cmd.clear = 1'b1;
               state_in  = S_EMIT;
            end else begin
               cmd.prep = 1'b1;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_SCALE_GO;
         end
         S_SCALE_GO: begin
            cmd.scale_go = 1'b1;
            state_in     = S_SCALE_WAIT;
         end
         S_SCALE_WAIT: begin
            if (status.div_done) state_in = S_POST;
         end
         S_POST: begin
            cmd.post = 1'b1;
            state_in = S_AVG_GO;
         end
         S_AVG_GO: begin
            cmd.avg_go = 1'b1;
            state_in   = S_AVG_WAIT;
         end
         S_AVG_WAIT: begin
            if (status.div_done) begin
               cmd.hold = 1'b1;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (emit_fire) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_fire) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: sv/tpca_datapath.sv
// ----------------------------------------------------------------------------
// tpca_datapath
// Calibration registers, per-axis offset and span, scaling product, two
// shared dividers, point history with running sums, held point and result
// register.
// ----------------------------------------------------------------------------
module tpca_datapath
   import tpca_pkg::*;
#(
   parameter int AVG_DEPTH     = 4,
   parameter int SCREEN_WIDTH  = 320,
   parameter int SCREEN_HEIGHT = 240
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CAL_W-1:0]     csr_data,
   input  req_type              req_data,
   output rsp_type              rsp_data,
   input  ctl_cmd_type          cmd,
   output ctl_status_type       status
);

   localparam int CNT_W = $clog2(AVG_DEPTH + 1);
   localparam int SUM_W = $clog2(2047 * AVG_DEPTH + 1);
   localparam logic [PT_W-1:0] RES_X = PT_W'(SCREEN_WIDTH);
   localparam logic [PT_W-1:0] RES_Y = PT_W'(SCREEN_HEIGHT);

   logic [CAL_W-1:0]  x_low_ff, y_low_ff, x_high_ff, y_high_ff;
   logic              inv_x_ff, inv_y_ff, swap_ff;
   req_type           item_ff;
   rsp_type           rsp_ff;

   logic [CAL_W-1:0]  raw_x, raw_y, cal_x, cal_y;
   logic [CAL_W-1:0]  off_x_ff, off_y_ff, span_x_ff, span_y_ff;
   logic [PROD_W-1:0] prod_x_ff, prod_y_ff;

   logic [PROD_W-1:0] num_x, num_y, quo_x, quo_y;
   logic [CAL_W-1:0]  den_x, den_y;
   logic              done_x, done_y, div_start;

   logic [PT_W-1:0]   sat_x, sat_y, pt_x, pt_y;
   logic [PT_W-1:0]   hist_x_ff [AVG_DEPTH];
   logic [PT_W-1:0]   hist_y_ff [AVG_DEPTH];
   logic [CNT_W-1:0]  cnt_ff;
   logic [SUM_W-1:0]  sum_x_ff, sum_y_ff;
   logic              full;
   logic [PT_W-1:0]   held_x_ff, held_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_low_ff  <= CAL_LOW_RESET;
         y_low_ff  <= CAL_LOW_RESET;
         x_high_ff <= CAL_HIGH_RESET;
         y_high_ff <= CAL_HIGH_RESET;
         inv_x_ff  <= 1'b1;
         inv_y_ff  <= 1'b1;
         swap_ff   <= 1'b1;
      end else if (csr_write) begin
         case (csr_index)
            REG_X_LOW_CAL:  x_low_ff  <= csr_data;
            REG_Y_LOW_CAL:  y_low_ff  <= csr_data;
            REG_X_HIGH_CAL: x_high_ff <= csr_data;
            REG_Y_HIGH_CAL: y_high_ff <= csr_data;
            REG_INVERT_X:   inv_x_ff  <= csr_data[0];
            REG_INVERT_Y:   inv_y_ff  <= csr_data[0];
            REG_SWAP_AXES:  swap_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) item_ff <= req_data;
   end

   assign raw_x = item_ff.raw_x_word[RAW_W-1:RAW_SHIFT];
   assign raw_y = item_ff.raw_y_word[RAW_W-1:RAW_SHIFT];
   assign cal_x = swap_ff ? raw_y : raw_x;
   assign cal_y = swap_ff ? raw_x : raw_y;

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         off_x_ff  <= (cal_x > x_low_ff) ? cal_x - x_low_ff : '0;
         off_y_ff  <= (cal_y > y_low_ff) ? cal_y - y_low_ff : '0;
         span_x_ff <= (x_high_ff > x_low_ff) ? x_high_ff - x_low_ff : CAL_W'(1);
         span_y_ff <= (y_high_ff > y_low_ff) ? y_high_ff - y_low_ff : CAL_W'(1);
      end
      if (cmd.mul) begin
         prod_x_ff <= PROD_W'(off_x_ff) * PROD_W'(RES_X);
         prod_y_ff <= PROD_W'(off_y_ff) * PROD_W'(RES_Y);
      end
   end

   assign div_start = cmd.scale_go | cmd.avg_go;
   assign num_x     = cmd.avg_go ? PROD_W'(sum_x_ff) : prod_x_ff;
   assign num_y     = cmd.avg_go ? PROD_W'(sum_y_ff) : prod_y_ff;
   assign den_x     = cmd.avg_go ? CAL_W'(cnt_ff) : span_x_ff;
   assign den_y     = cmd.avg_go ? CAL_W'(cnt_ff) : span_y_ff;

   tpca_div #(.NUM_W(PROD_W), .DEN_W(CAL_W)) u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num_x),
      .divisor  (den_x),
      .quotient (quo_x),
      .done     (done_x)
   );

   tpca_div #(.NUM_W(PROD_W), .DEN_W(CAL_W)) u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num_y),
      .divisor  (den_y),
      .quotient (quo_y),
      .done     (done_y)
   );

   assign sat_x = (quo_x > PROD_W'(RES_X)) ? RES_X : quo_x[PT_W-1:0];
   assign sat_y = (quo_y > PROD_W'(RES_Y)) ? RES_Y : quo_y[PT_W-1:0];
   assign pt_x  = inv_x_ff ? RES_X - sat_x : sat_x;
   assign pt_y  = inv_y_ff ? RES_Y - sat_y : sat_y;
   assign full  = cnt_ff == CNT_W'(AVG_DEPTH);

   always_ff @(posedge clock) begin
      if (cmd.post) begin
         hist_x_ff[0] <= pt_x;
         hist_y_ff[0] <= pt_y;
         for (int i = 1; i < AVG_DEPTH; i++) begin
            hist_x_ff[i] <= hist_x_ff[i-1];
            hist_y_ff[i] <= hist_y_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         cnt_ff   <= '0;
         sum_x_ff <= '0;
         sum_y_ff <= '0;
      end else if (cmd.post) begin
         if (!full) cnt_ff <= cnt_ff + 1'b1;
         sum_x_ff <= sum_x_ff + SUM_W'(pt_x)
                   - (full ? SUM_W'(hist_x_ff[AVG_DEPTH-1]) : '0);
         sum_y_ff <= sum_y_ff + SUM_W'(pt_y)
                   - (full ? SUM_W'(hist_y_ff[AVG_DEPTH-1]) : '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_x_ff <= '0;
         held_y_ff <= '0;
      end else if (cmd.hold) begin
         held_x_ff <= quo_x[PT_W-1:0];
         held_y_ff <= quo_y[PT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff.point_x <= held_x_ff;
         rsp_ff.point_y <= held_y_ff;
         rsp_ff.pressed <= !item_ff.pen_line;
      end
   end

   assign rsp_data        = rsp_ff;
   assign status.pen_line = item_ff.pen_line;
   assign status.div_done = done_x & done_y;

endmodule

FILE: sv/touch_point_calibrate_average.sv
// ----------------------------------------------------------------------------
// touch_point_calibrate_average
// Touch poll calibration, scaling and moving average.
// ----------------------------------------------------------------------------
// One item is one poll. A touched poll runs two passes of the 23-step
// shift-subtract dividers (scaling by screen size over calibrated span, then
// averaging over up to AVG_DEPTH points) between acceptance and the result
// register; a released poll skips both and clears the history. The next poll
// is taken once the result is in the output register, even if that result has
// not yet been taken. Calibration registers are written through
// csr_write/csr_index/csr_data; a write during a poll can affect that poll.
// ----------------------------------------------------------------------------
module touch_point_calibrate_average
   import tpca_pkg::*;
#(
   parameter int AVG_DEPTH     = 4,
   parameter int SCREEN_WIDTH  = 320,
   parameter int SCREEN_HEIGHT = 240
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CAL_W-1:0]     csr_data
);

   ctl_cmd_type    cmd;
   ctl_status_type status;

   tpca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tpca_datapath #(
      .AVG_DEPTH     (AVG_DEPTH),
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

FILE: dv/tb_touch_point_calibrate_average.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_touch_point_calibrate_average
// Self-checking bench for touch poll calibration, scaling and averaging.
// ----------------------------------------------------------------------------
// A scoreboard keeps its own copy of the calibration registers, the point
// history and the held point, works out the point for every accepted poll
// and compares each returned point field by field. Directed polls cover raw
// extremes, released polls, history wrap, reversed and empty spans and
// saturation; random phases then run touch bursts with releases under random
// calibration settings, random idling on both sides, one long output
// hold-off and one full drain in the middle of a phase.
// ----------------------------------------------------------------------------
module tb_touch_point_calibrate_average;
   import tpca_pkg::*;

   localparam int AVG_DEPTH     = 4;
   localparam int SCREEN_WIDTH  = 320;
   localparam int SCREEN_HEIGHT = 240;
   localparam int CYCLE_LIMIT   = 800000;
   localparam int LONG_HOLD     = 400;
   localparam int PHASE_POLLS   = 200;

   typedef struct {
      logic [CAL_W-1:0] x_low;
      logic [CAL_W-1:0] y_low;
      logic [CAL_W-1:0] x_high;
      logic [CAL_W-1:0] y_high;
      logic             invert_x;
      logic             invert_y;
      logic             swap_axes;
   } cal_setting_type;

   class point_scoreboard;
      logic [CAL_W-1:0] x_low, y_low, x_high, y_high;
      logic             inv_x, inv_y, swap;
      logic [PT_W-1:0]  hist_x [AVG_DEPTH];
      logic [PT_W-1:0]  hist_y [AVG_DEPTH];
      int unsigned      hist_count;
      logic [PT_W-1:0]  held_x, held_y;
      rsp_type          expected_q [$];
      int               errors;

      function new();
         x_low      = CAL_LOW_RESET;
         y_low      = CAL_LOW_RESET;
         x_high     = CAL_HIGH_RESET;
         y_high     = CAL_HIGH_RESET;
         inv_x      = 1'b1;
         inv_y      = 1'b1;
         swap       = 1'b1;
         hist_count = 0;
         held_x     = '0;
         held_y     = '0;
         errors     = 0;
         foreach (hist_x[i]) begin
            hist_x[i] = '0;
            hist_y[i] = '0;
         end
      endfunction

      function void set_reg(csr_index_type idx, logic [CAL_W-1:0] value);
         case (idx)
            REG_X_LOW_CAL:  x_low  = value;
            REG_Y_LOW_CAL:  y_low  = value;
            REG_X_HIGH_CAL: x_high = value;
            REG_Y_HIGH_CAL: y_high = value;
            REG_INVERT_X:   inv_x  = value[0];
            REG_INVERT_Y:   inv_y  = value[0];
            REG_SWAP_AXES:  swap   = value[0];
            default: ;
         endcase
      endfunction

      function logic [PT_W-1:0] scale_axis(logic [CAL_W-1:0] raw, logic [CAL_W-1:0] lo,
                                           logic [CAL_W-1:0] hi, int unsigned res,
                                           logic inv);
         int unsigned offset, span, v;
         offset = (raw > lo) ? (int'(raw) - int'(lo)) : 0;
         span   = (hi > lo) ? (int'(hi) - int'(lo)) : 1;
         v      = offset * res / span;
         if (v > res) v = res;
         if (inv) v = res - v;
         return v[PT_W-1:0];
      endfunction

      function void note_poll(req_type p);
         logic [CAL_W-1:0] rx, ry, t;
         int unsigned      sum_x, sum_y;
         rsp_type          r;
         rx = p.raw_x_word[RAW_W-1:RAW_SHIFT];
         ry = p.raw_y_word[RAW_W-1:RAW_SHIFT];
         if (!p.pen_line) begin
            if (swap) begin
               t  = rx;
               rx = ry;
               ry = t;
            end
            for (int i = AVG_DEPTH - 1; i > 0; i--) begin
               hist_x[i] = hist_x[i-1];
               hist_y[i] = hist_y[i-1];
            end
            hist_x[0] = scale_axis(rx, x_low, x_high, SCREEN_WIDTH, inv_x);
            hist_y[0] = scale_axis(ry, y_low, y_high, SCREEN_HEIGHT, inv_y);
            if (hist_count < AVG_DEPTH) hist_count++;
            sum_x = 0;
            sum_y = 0;
            for (int i = 0; i < hist_count; i++) begin
               sum_x += 32'(hist_x[i]);
               sum_y += 32'(hist_y[i]);
            end
            held_x    = PT_W'(sum_x / hist_count);
            held_y    = PT_W'(sum_y / hist_count);
            r.pressed = 1'b1;
         end else begin
            hist_count = 0;
            r.pressed  = 1'b0;
         end
         r.point_x = held_x;
         r.point_y = held_y;
         expected_q.push_back(r);
      endfunction

      function void compare_field(string field, int unsigned want, int unsigned got);
         if (want != got) begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
         end
      endfunction

      function void check_point(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected point: expected none, actual x=%0d y=%0d pressed=%0b",
                     $time, got.point_x, got.point_y, got.pressed);
            return;
         end
         want = expected_q.pop_front();
         compare_field("point_x", 32'(want.point_x), 32'(got.point_x));
         compare_field("point_y", 32'(want.point_y), 32'(got.point_y));
         compare_field("pressed", 32'(want.pressed), 32'(got.pressed));
      endfunction
   endclass

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_stall;
   req_type              req_data    = '0;
   logic                 rsp_valid;
   logic                 rsp_stall   = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_write   = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index   = '0;
   logic [CAL_W-1:0]     csr_data    = '0;

   point_scoreboard      sb;
   cal_setting_type      cur_cal;
   int unsigned          cycle_count = 0;
   bit                   send_idle_on;
   bit                   rsp_idle_on;
   bit                   long_hold_pending = 1'b0;

   touch_point_calibrate_average #(
      .AVG_DEPTH     (AVG_DEPTH),
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_point(rsp_data);
   end

   // output side: stall before each item (random hold if idling, or long hold)
   initial begin
      int unsigned hold;
      while (reset) @(posedge clock);
      forever begin
         if (long_hold_pending) begin
            hold = LONG_HOLD;
            long_hold_pending = 1'b0;
         end else if (rsp_idle_on) begin
            hold = $urandom_range(0, 19);
         end else begin
            hold = 0;
         end
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   task automatic send_poll(req_type p);
      int unsigned gap;
      gap = send_idle_on ? $urandom_range(0, 19) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      do @(posedge clock); while (req_stall);
      sb.note_poll(p);
   endtask

   task automatic drain_points();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CAL_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      sb.set_reg(idx, value);
   endtask

   task automatic apply_cal(cal_setting_type c);
      logic [CAL_W-2:0] junk;
      write_reg(REG_X_LOW_CAL, c.x_low);
      write_reg(REG_Y_LOW_CAL, c.y_low);
      write_reg(REG_X_HIGH_CAL, c.x_high);
      write_reg(REG_Y_HIGH_CAL, c.y_high);
      junk = (CAL_W-1)'($urandom);
      write_reg(REG_INVERT_X, {junk, c.invert_x});
      junk = (CAL_W-1)'($urandom);
      write_reg(REG_INVERT_Y, {junk, c.invert_y});
      junk = (CAL_W-1)'($urandom);
      write_reg(REG_SWAP_AXES, {junk, c.swap_axes});
      csr_write <= 1'b0;
      cur_cal = c;
   endtask

   function automatic logic [CAL_W-1:0] pick_cal(int unsigned lo_b, int unsigned hi_b);
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return CAL_W'($urandom_range(hi_b, lo_b));
      endcase
   endfunction

   function automatic logic [RAW_W-1:0] pick_word(logic [CAL_W-1:0] lo, logic [CAL_W-1:0] hi);
      logic [CAL_W-1:0]            v;
      logic [RAW_SHIFT-1:0]        nibble;
      nibble = RAW_SHIFT'($urandom);
      if ($urandom_range(0, 9) < 7) v = CAL_W'($urandom_range(lo, hi));
      else v = CAL_W'($urandom);
      return {v, nibble};
   endfunction

   task automatic run_random_polls(int unsigned count);
      int unsigned sent;
      req_type     p;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 9) == 0) begin
            p.pen_line   = 1'($urandom);
            p.raw_x_word = RAW_W'($urandom);
            p.raw_y_word = RAW_W'($urandom);
            send_poll(p);
            sent++;
         end else begin
            repeat ($urandom_range(1, 10)) begin
               p.pen_line = 1'b0;
               if (cur_cal.swap_axes) begin
                  p.raw_x_word = pick_word(cur_cal.y_low, cur_cal.y_high);
                  p.raw_y_word = pick_word(cur_cal.x_low, cur_cal.x_high);
               end else begin
                  p.raw_x_word = pick_word(cur_cal.x_low, cur_cal.x_high);
                  p.raw_y_word = pick_word(cur_cal.y_low, cur_cal.y_high);
               end
               send_poll(p);
               sent++;
            end
            repeat ($urandom_range(1, 3)) begin
               p.pen_line   = 1'b1;
               p.raw_x_word = RAW_W'($urandom);
               p.raw_y_word = RAW_W'($urandom);
               send_poll(p);
               sent++;
            end
         end
      end
   endtask

   initial begin
      cal_setting_type c;
      sb      = new();
      cur_cal = '{CAL_LOW_RESET, CAL_LOW_RESET, CAL_HIGH_RESET, CAL_HIGH_RESET,
                  1'b1, 1'b1, 1'b1};
      send_idle_on = 1'b1;
      rsp_idle_on  = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset calibration: release before any touch, raw extremes, history wrap
      send_poll(req_type'{1'b1, 16'hFFFF, 16'hFFFF});
      send_poll(req_type'{1'b0, 16'h0000, 16'h0000});
      send_poll(req_type'{1'b0, 16'hFFFF, 16'hFFFF});
      send_poll(req_type'{1'b0, 16'h0C8F, 16'hED8F});
      send_poll(req_type'{1'b0, 16'h7FF0, 16'h8000});
      send_poll(req_type'{1'b0, 16'h1234, 16'hABCD});
      send_poll(req_type'{1'b0, 16'hFFFF, 16'h0000});
      send_poll(req_type'{1'b1, 16'h0000, 16'h0000});
      send_poll(req_type'{1'b0, 16'h5555, 16'hAAAA});
      send_poll(req_type'{1'b1, 16'hAAAA, 16'h5555});
      drain_points();

      // reversed x span, empty y span
      apply_cal('{12'd3000, 12'd2000, 12'd1000, 12'd2000, 1'b0, 1'b0, 1'b0});
      send_poll(req_type'{1'b0, 16'h0000, 16'hFFFF});
      send_poll(req_type'{1'b0, 16'hBB80, 16'h7D00});
      send_poll(req_type'{1'b0, 16'hBB90, 16'h7D10});
      send_poll(req_type'{1'b0, 16'hFFFF, 16'hFFFF});
      send_poll(req_type'{1'b1, 16'h0000, 16'h0000});
      drain_points();

      apply_cal('{12'd0, 12'd0, 12'd4095, 12'd4095, 1'b1, 1'b0, 1'b1});
      send_poll(req_type'{1'b0, 16'h0000, 16'h0000});
      send_poll(req_type'{1'b0, 16'hFFFF, 16'hFFFF});
      send_poll(req_type'{1'b0, 16'hFFFF, 16'h0000});
      send_poll(req_type'{1'b1, 16'hFFFF, 16'hFFFF});
      drain_points();

      apply_cal('{12'd4095, 12'd0, 12'd0, 12'd4095, 1'b0, 1'b1, 1'b0});
      send_poll(req_type'{1'b0, 16'hFFFF, 16'hFFFF});
      send_poll(req_type'{1'b0, 16'h0000, 16'h0000});
      drain_points();

      for (int ph = 0; ph < 8; ph++) begin
         c.x_low     = pick_cal(0, 1800);
         c.y_low     = pick_cal(0, 1800);
         c.x_high    = pick_cal(2200, 4095);
         c.y_high    = pick_cal(2200, 4095);
         c.invert_x  = 1'($urandom);
         c.invert_y  = 1'($urandom);
         c.swap_axes = 1'($urandom);
         apply_cal(c);
         send_idle_on = (ph % 4) != 1;
         rsp_idle_on  = (ph % 4) != 2;
         if (ph == 1) begin
            // hold the output while polls keep coming, then drain mid-phase
            long_hold_pending = 1'b1;
            run_random_polls(PHASE_POLLS / 2);
            drain_points();
            run_random_polls(PHASE_POLLS / 2);
         end else begin
            run_random_polls(PHASE_POLLS);
         end
         drain_points();
      end

      repeat (60) @(posedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
